// ===== hdl/kst_pkg.sv =====
package kst_pkg;

   // key table geometry
   localparam int KEY_COUNT = 128;
   localparam int KEY_W     = $clog2(KEY_COUNT);

   localparam int CODE_W = 8;
   localparam int MOD_W  = 6;
   localparam int CNT_W  = 2;

   // flag bits of a key table entry
   localparam int FL_INVALID = 0;
   localparam int FL_SHIFT   = 1;
   localparam int FL_LOCK    = 2;
   localparam int FL_KEYPAD  = 3;
   localparam int FL_CAPS    = 4;
   localparam int FL_NUM     = 5;
   localparam int FL_CTRLOK  = 6;
   localparam int FL_DUP     = 7;

   // modifier bits
   localparam int MB_SHIFT1 = 0;
   localparam int MB_SHIFT2 = 1;
   localparam int MB_CAPS   = 2;
   localparam int MB_NUM    = 3;
   localparam int MB_CTRL   = 4;
   localparam int MB_ALT    = 5;

   // report code bits and the alt marker
   localparam logic [CODE_W-1:0] REP_UPPER = 8'h01;
   localparam logic [CODE_W-1:0] REP_ALT   = 8'h02;
   localparam logic [CODE_W-1:0] REP_CTRL  = 8'h04;
   localparam logic [CODE_W-1:0] ALT_BIT   = 8'h80;

   typedef enum logic {
      ACT_KEY   = 1'b0,
      ACT_WRITE = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      REG_KEYPAD_MODE = 3'd0,
      REG_ACCEPT_KEYS = 3'd1,
      REG_FUNC_FIRST  = 3'd2,
      REG_FUNC_LAST   = 3'd3,
      REG_REPORT_CODE = 3'd4
   } csr_index_type;

   // one table word, flags in the lowest byte
   typedef struct packed {
      logic [CODE_W-1:0] control;
      logic [CODE_W-1:0] upper;
      logic [CODE_W-1:0] lower;
      logic [CODE_W-1:0] flags;
   } entry_type;

   typedef struct packed {
      logic              keypad_mode;
      logic              accept_keys;
      logic [CODE_W-1:0] func_first;
      logic [CODE_W-1:0] func_last;
      logic [CODE_W-1:0] report_code;
   } cfg_type;

   typedef struct packed {
      logic [CNT_W-1:0]  cnt;
      logic [CODE_W-1:0] code0;
      logic [CODE_W-1:0] code1;
      logic [CODE_W-1:0] code2;
      logic [MOD_W-1:0]  mods_next;
   } xlate_type;

endpackage

// ===== hdl/kst_ram.sv =====
module kst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/kst_xlate.sv =====
module kst_xlate (
   input  logic                      item_valid,
   input  logic                      is_write,
   input  logic                      released,
   input  kst_pkg::entry_type        entry,
   input  logic [kst_pkg::MOD_W-1:0] mods,
   input  kst_pkg::cfg_type          cfg,
   output kst_pkg::xlate_type        res
);

   import kst_pkg::*;

   logic [CODE_W-1:0] code;
   logic [CODE_W-1:0] rep;
   logic [MOD_W-1:0]  mask;
   logic              upper_sel;
   logic              drop;
   logic              is_func;
   logic              is_key;

   always_comb begin
      mask      = entry.control[MOD_W-1:0];
      upper_sel = mods[MB_SHIFT1] | mods[MB_SHIFT2];
      if ((entry.flags[FL_CAPS] & mods[MB_CAPS]) | (entry.flags[FL_NUM] & mods[MB_NUM])) begin
         upper_sel = ~upper_sel;
      end

      // code choice
      drop = 1'b0;
      if (cfg.keypad_mode && entry.flags[FL_KEYPAD]) begin
         code = entry.control;
      end else if (mods != '0) begin
         if (mods[MB_CTRL]) begin
            code = entry.control;
            drop = ~entry.flags[FL_CTRLOK];
         end else if (upper_sel) begin
            code = entry.upper;
         end else begin
            code = entry.lower;
         end
         if (mods[MB_ALT]) begin
            code = code | ALT_BIT;
         end
      end else begin
         code = entry.lower;
      end

      is_func = (code >= cfg.func_first) && (code <= cfg.func_last);
      rep     = cfg.report_code;
      if (mods[MB_SHIFT1] | mods[MB_SHIFT2]) begin
         rep = rep | REP_UPPER;
      end
      if (mods[MB_ALT]) begin
         rep = rep | REP_ALT;
      end
      if (mods[MB_CTRL]) begin
         rep = rep | REP_CTRL;
      end

      is_key        = item_valid && !is_write && !entry.flags[FL_INVALID];
      res           = '0;
      res.mods_next = mods;
      res.code0     = code;
      res.code1     = entry.flags[FL_DUP] ? code : rep;
      res.code2     = rep;

      if (is_key) begin
         if (entry.flags[FL_SHIFT] || entry.flags[FL_LOCK]) begin
            if (entry.flags[FL_LOCK]) begin
               if (released) begin
                  res.mods_next = mods ^ mask;
               end
            end else if (released) begin
               res.mods_next = mods & ~mask;
            end else begin
               res.mods_next = mods | mask;
            end
         end else if (!released && cfg.accept_keys && !drop) begin
            res.cnt = CNT_W'(1) + CNT_W'(entry.flags[FL_DUP]) + CNT_W'(is_func);
         end
      end
   end

endmodule

// ===== hdl/keyboard_scancode_translator.sv =====
// keyboard scancode translator
// req channel: one beat per key event or key table write; tuser selects which
// (0 key event, 1 table write). a table write stores the entry and gives no
// result. key events look up the table and update the modifier bits or give
// zero to three character codes on the rsp channel, tlast on the last one.
// csr port: plain write strobe, index and data, taken on any edge with csr_we;
// write only while the block is idle.
// a key event's table entry is read into the ram register on the edge that
// takes the req beat; the translate stage works on it combinationally and loads
// its result beats into the output register once that register is free.
// throughput: one req beat a cycle while each result finds the output register
// free; a key event with n result beats (n up to 3) holds the single output
// register until all are taken, handing out one beat a cycle while rsp_tready is high.
// reset: modifier bits, csr registers and all valid flags clear; the key table
// holds garbage until written and must be loaded before keys are sent.
// stall: with rsp_tready low the output register holds, the translate stage
// then waits on an item with results, and req_tready drops once it is full.
module keyboard_scancode_translator (
   input  logic        clock,
   input  logic        reset,
   // req: key_number[6:0], key_released[7], entry_flags[15:8],
   // entry_lower[23:16], entry_upper[31:24], entry_control[39:32]
   input  logic [39:0] req_tdata,
   // req: action[0]
   input  logic        req_tuser,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rsp: char_code[7:0]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   import kst_pkg::*;

   // request beat unpacked
   logic [KEY_W-1:0] req_key;
   logic             req_released;
   entry_type        req_entry;
   logic             req_fire;

   // translate stage
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_write_ff;
   logic             s1_released_ff;
   logic             s1_fire;
   entry_type        rd_entry;
   xlate_type        res;

   // modifier bits and csr registers
   logic [MOD_W-1:0] mods_ff, mods_in;
   cfg_type          cfg_ff, cfg_in;

   // output register, drains code0 first
   logic [CNT_W-1:0]  out_cnt_ff, out_cnt_in;
   logic [CODE_W-1:0] out_code0_ff, out_code0_in;
   logic [CODE_W-1:0] out_code1_ff, out_code1_in;
   logic [CODE_W-1:0] out_code2_ff, out_code2_in;
   logic              out_take;
   logic              out_free;
   logic              out_load;

   assign req_key      = req_tdata[KEY_W-1:0];
   assign req_released = req_tdata[7];
   assign req_entry    = entry_type'(req_tdata[39:8]);

   assign rsp_tvalid = out_cnt_ff != '0;
   assign rsp_tlast  = out_cnt_ff == CNT_W'(1);
   assign rsp_tdata  = out_code0_ff;
   assign out_take   = rsp_tvalid && rsp_tready;

   // the output register can take a new item when empty or on its last beat
   assign out_free   = (out_cnt_ff == '0) || (out_cnt_ff == CNT_W'(1) && rsp_tready);
   assign s1_fire    = s1_valid_ff && ((res.cnt == '0) || out_free);
   assign out_load   = s1_fire && (res.cnt != '0);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;

   // key table: written and read straight from the req beat, read data
   // stays put while the translate stage waits
   kst_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(KEY_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (req_fire && req_tuser == ACT_WRITE),
      .wr_addr (req_key),
      .wr_data (req_entry),
      .rd_en   (req_fire),
      .rd_addr (req_key),
      .rd_data (rd_entry)
   );

   kst_xlate u_xlate (
      .item_valid (s1_valid_ff),
      .is_write   (s1_write_ff),
      .released   (s1_released_ff),
      .entry      (rd_entry),
      .mods       (mods_ff),
      .cfg        (cfg_ff),
      .res        (res)
   );

   // csr writes, indexes beyond the list are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_KEYPAD_MODE: cfg_in.keypad_mode = csr_wdata[0];
            REG_ACCEPT_KEYS: cfg_in.accept_keys = csr_wdata[0];
            REG_FUNC_FIRST:  cfg_in.func_first  = csr_wdata;
            REG_FUNC_LAST:   cfg_in.func_last   = csr_wdata;
            REG_REPORT_CODE: cfg_in.report_code = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      mods_in = s1_fire ? res.mods_next : mods_ff;
   end

   // output register: load a fresh item or shift on each taken beat
   always_comb begin
      out_cnt_in   = out_cnt_ff;
      out_code0_in = out_code0_ff;
      out_code1_in = out_code1_ff;
      out_code2_in = out_code2_ff;
      if (out_load) begin
         out_cnt_in   = res.cnt;
         out_code0_in = res.code0;
         out_code1_in = res.code1;
         out_code2_in = res.code2;
      end else if (out_take) begin
         out_cnt_in   = out_cnt_ff - CNT_W'(1);
         out_code0_in = out_code1_ff;
         out_code1_in = out_code2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         mods_ff     <= '0;
         cfg_ff      <= '0;
         out_cnt_ff  <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         mods_ff     <= mods_in;
         cfg_ff      <= cfg_in;
         out_cnt_ff  <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_write_ff    <= req_tuser;
         s1_released_ff <= req_released;
      end
      out_code0_ff <= out_code0_in;
      out_code1_ff <= out_code1_in;
      out_code2_ff <= out_code2_in;
   end

   // modifier bits only move when the translate stage retires an item
   a_mods_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> $stable(mods_ff))
      else $error("modifier bits changed without a retiring item");

   // a new item never overwrites beats still owed to the receiver
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (out_cnt_ff == '0 || (out_cnt_ff == CNT_W'(1) && rsp_tready)))
      else $error("output register loaded while beats pending");

   // each taken beat without a load lowers the pending count by one
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (out_take && !out_load) |=> out_cnt_ff == $past(out_cnt_ff) - CNT_W'(1))
      else $error("pending beat count out of step");

   // table writes give no result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_write_ff) |-> res.cnt == '0)
      else $error("table write produced a result");

endmodule

// ===== tb/scancode_checker.sv =====
`timescale 1ns / 1ps

module scancode_checker
   import kst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [39:0] req_tdata,
   input  logic        req_tuser,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   output int          fail_count,
   output int          pending
);

   typedef struct {
      logic [CODE_W-1:0] code;
      logic              last;
   } char_beat_type;

   entry_type         keymap [KEY_COUNT];
   logic [MOD_W-1:0]  held_mods;
   cfg_type           cfg;
   char_beat_type     expected_codes [$];

   task automatic report_mismatch(input string what);
      $display("[%0t] checker: %s", $time, what);
      fail_count++;
   endtask

   // works out the codes that one key event gives and updates the held modifiers
   task automatic translate_key_event(input logic [KEY_W-1:0] key, input logic released);
      entry_type         e;
      logic [MOD_W-1:0]  mask;
      logic [CODE_W-1:0] code;
      logic [CODE_W-1:0] report;
      logic              upper_case;
      logic [CODE_W-1:0] out_codes [$];
      e = keymap[key];
      mask = e.control[MOD_W-1:0];
      if (e.flags[FL_INVALID]) return;
      if (e.flags[FL_SHIFT] || e.flags[FL_LOCK]) begin
         if (e.flags[FL_LOCK]) begin
            if (released) held_mods ^= mask;
         end else if (released) begin
            held_mods &= ~mask;
         end else begin
            held_mods |= mask;
         end
         return;
      end
      if (released || !cfg.accept_keys) return;
      if (cfg.keypad_mode && e.flags[FL_KEYPAD]) begin
         code = e.control;
      end else begin
         upper_case = held_mods[MB_SHIFT1] | held_mods[MB_SHIFT2];
         if ((e.flags[FL_CAPS] && held_mods[MB_CAPS]) || (e.flags[FL_NUM] && held_mods[MB_NUM]))
            upper_case = !upper_case;
         if (held_mods[MB_CTRL]) begin
            if (!e.flags[FL_CTRLOK]) return;
            code = e.control;
         end else begin
            code = upper_case ? e.upper : e.lower;
         end
         if (held_mods[MB_ALT]) code |= ALT_BIT;
      end
      out_codes.push_back(code);
      if (e.flags[FL_DUP]) out_codes.push_back(code);
      if (code >= cfg.func_first && code <= cfg.func_last) begin
         report = cfg.report_code;
         if (held_mods[MB_SHIFT1] || held_mods[MB_SHIFT2]) report |= REP_UPPER;
         if (held_mods[MB_ALT]) report |= REP_ALT;
         if (held_mods[MB_CTRL]) report |= REP_CTRL;
         out_codes.push_back(report);
      end
      foreach (out_codes[i])
         expected_codes.push_back('{out_codes[i], i == out_codes.size() - 1});
   endtask

   always @(posedge clock) begin
      char_beat_type want;
      if (reset) begin
         held_mods = '0;
         cfg = '0;
         expected_codes.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               REG_KEYPAD_MODE: cfg.keypad_mode = csr_wdata[0];
               REG_ACCEPT_KEYS: cfg.accept_keys = csr_wdata[0];
               REG_FUNC_FIRST:  cfg.func_first  = csr_wdata;
               REG_FUNC_LAST:   cfg.func_last   = csr_wdata;
               REG_REPORT_CODE: cfg.report_code = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_codes.size() == 0) begin
               report_mismatch($sformatf("unexpected rsp beat code %02h last %b",
                                         rsp_tdata, rsp_tlast));
            end else begin
               want = expected_codes.pop_front();
               if (rsp_tdata !== want.code)
                  report_mismatch($sformatf("char code %02h, wanted %02h", rsp_tdata, want.code));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("tlast %b on code %02h, wanted %b",
                                            rsp_tlast, rsp_tdata, want.last));
            end
         end
         if (req_tvalid && req_tready) begin
            if (action_type'(req_tuser) == ACT_WRITE)
               keymap[req_tdata[KEY_W-1:0]] = entry_type'(req_tdata[39:8]);
            else
               translate_key_event(req_tdata[KEY_W-1:0], req_tdata[7]);
         end
      end
      pending <= expected_codes.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import kst_pkg::*;

   // cycles with nothing moving on either channel before the run is called hung
   localparam int STALL_LIMIT      = 2000;
   localparam int PHASES           = 6;
   localparam int RANDOM_PER_PHASE = 60;

   // table flag masks
   localparam logic [7:0] FLAG_INVALID = 8'h01 << FL_INVALID;
   localparam logic [7:0] FLAG_SHIFT   = 8'h01 << FL_SHIFT;
   localparam logic [7:0] FLAG_LOCK    = 8'h01 << FL_LOCK;
   localparam logic [7:0] FLAG_CAPS    = 8'h01 << FL_CAPS;
   localparam logic [7:0] FLAG_CTRLOK  = 8'h01 << FL_CTRLOK;
   localparam logic [7:0] FLAG_DUP     = 8'h01 << FL_DUP;

   // modifier masks as held in the control byte of shift and lock keys
   localparam logic [7:0] MOD_SHIFT1 = 8'h01 << MB_SHIFT1;
   localparam logic [7:0] MOD_CAPS   = 8'h01 << MB_CAPS;
   localparam logic [7:0] MOD_CTRL   = 8'h01 << MB_CTRL;
   localparam logic [7:0] MOD_ALT    = 8'h01 << MB_ALT;

   logic        clock = 1'b0;
   logic        reset;
   logic [39:0] req_tdata;
   logic        req_tuser;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [7:0]  csr_wdata;

   int fail_count;
   int pending;
   // percentage of cycles in which each side holds back
   int send_idle = 0;
   int recv_idle = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   keyboard_scancode_translator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   scancode_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   function automatic entry_type mk_entry(input logic [7:0] flags, lower, upper, control);
      return {control, upper, lower, flags};
   endfunction

   // mostly plain character keys, with a sprinkling of shift, lock and invalid keys
   function automatic entry_type rand_entry();
      entry_type e;
      int        pick;
      e = entry_type'($urandom);
      pick = $urandom_range(99);
      if (pick < 8) begin
         e.flags |= FLAG_INVALID;
      end else if (pick < 17) begin
         e.flags = (e.flags & ~(FLAG_INVALID | FLAG_LOCK)) | FLAG_SHIFT;
         if ($urandom_range(3) != 0) e.control = 8'h01 << $urandom_range(MOD_W - 1);
      end else if (pick < 22) begin
         e.flags = (e.flags & ~FLAG_INVALID) | FLAG_LOCK;
         if ($urandom_range(3) != 0) e.control = 8'h01 << $urandom_range(MOD_W - 1);
      end else begin
         e.flags &= ~(FLAG_INVALID | FLAG_SHIFT | FLAG_LOCK);
      end
      return e;
   endfunction

   // one req beat; returns on the edge that takes it, tvalid still high
   task automatic drive_req(input action_type act, input logic [KEY_W-1:0] key,
                            input logic released, input entry_type e);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {e, released, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // entry fields of a key event are don't-care, so fill them with noise
   task automatic key_event(input logic [KEY_W-1:0] key, input logic released);
      drive_req(ACT_KEY, key, released, entry_type'($urandom));
   endtask

   task automatic load_key(input logic [KEY_W-1:0] key, input entry_type e);
      drive_req(ACT_WRITE, key, 1'($urandom), e);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // keypad mode, accept, function range and report base for each phase
   task automatic set_phase_config(input int phase);
      logic       keypad, accept;
      logic [7:0] fk_first, fk_last, report;
      case (phase)
         0: begin keypad = 1'b0; accept = 1'b1; fk_first = 8'h00; fk_last = 8'h1f; report = 8'h80; end
         1: begin keypad = 1'b1; accept = 1'b1; fk_first = 8'hf0; fk_last = 8'hff; report = 8'hf8; end
         // keys refused, and an empty function range
         2: begin keypad = 1'b0; accept = 1'b0; fk_first = 8'h80; fk_last = 8'h7f; report = 8'h55; end
         // every code counts as a function key
         3: begin keypad = 1'b0; accept = 1'b1; fk_first = 8'h00; fk_last = 8'hff; report = 8'hff; end
         4: begin keypad = 1'b1; accept = 1'b1; fk_first = 8'hff; fk_last = 8'h00; report = 8'h00; end
         default: begin
            keypad   = 1'($urandom);
            accept   = 1'b1;
            fk_first = 8'($urandom_range(127));
            fk_last  = 8'($urandom_range(255, 128));
            report   = 8'($urandom);
         end
      endcase
      write_reg(REG_KEYPAD_MODE, {7'd0, keypad});
      write_reg(REG_ACCEPT_KEYS, {7'd0, accept});
      write_reg(REG_FUNC_FIRST, fk_first);
      write_reg(REG_FUNC_LAST, fk_last);
      write_reg(REG_REPORT_CODE, report);
      csr_we <= 1'b0;
   endtask

   // drop tvalid, let every expected code come out, then let silent beats settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // hand-picked beats through each corner of the translation
   task automatic directed_keys();
      // all-ones entry marked invalid: pressing it gives nothing
      load_key(7'd127, mk_entry(8'hff, 8'hff, 8'hff, 8'hff));
      key_event(7'd127, 1'b0);
      // plain key, code zero sits in the function range so a report follows
      load_key(7'd0, mk_entry(8'h00, 8'h00, 8'hff, 8'h00));
      key_event(7'd0, 1'b0);
      key_event(7'd0, 1'b1);
      // shift key with all modifier bits: ctrl held drops a key that is not ctrl-ok
      load_key(7'd1, mk_entry(FLAG_SHIFT, 8'h00, 8'h00, 8'hff));
      key_event(7'd1, 1'b0);
      key_event(7'd0, 1'b0);
      key_event(7'd1, 1'b1);
      load_key(7'd2, mk_entry(FLAG_SHIFT, 8'h00, 8'h00, MOD_SHIFT1));
      load_key(7'd3, mk_entry(FLAG_LOCK, 8'h00, 8'h00, MOD_CAPS));
      load_key(7'd4, mk_entry(FLAG_CAPS | FLAG_DUP | FLAG_CTRLOK, 8'h61, 8'h41, 8'h01));
      // shifted letter, given twice
      key_event(7'd2, 1'b0);
      key_event(7'd4, 1'b0);
      key_event(7'd4, 1'b1);
      key_event(7'd2, 1'b1);
      // caps lock toggles on release only
      key_event(7'd3, 1'b0);
      key_event(7'd3, 1'b1);
      key_event(7'd4, 1'b0);
      // ctrl gives the control code plus report, then alt sets the top bit
      load_key(7'd5, mk_entry(FLAG_SHIFT, 8'h00, 8'h00, MOD_CTRL));
      load_key(7'd6, mk_entry(FLAG_SHIFT, 8'h00, 8'h00, MOD_ALT));
      key_event(7'd5, 1'b0);
      key_event(7'd4, 1'b0);
      key_event(7'd6, 1'b0);
      key_event(7'd4, 1'b0);
      key_event(7'd5, 1'b1);
      key_event(7'd6, 1'b1);
      key_event(7'd3, 1'b1);
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         // receiver lazy first, then sender lazy, then both flat out
         case (phase / 2)
            0: begin send_idle = 36; recv_idle = 64; end
            1: begin send_idle = 64; recv_idle = 36; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         set_phase_config(phase);
         if (phase == 0) begin
            // fill every table entry before any key can look one up
            for (int k = 0; k < KEY_COUNT; k++) load_key(7'(k), rand_entry());
            directed_keys();
         end
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if ($urandom_range(99) < 8)
               load_key(7'($urandom_range(KEY_COUNT - 1)), rand_entry());
            else
               key_event(7'($urandom_range(KEY_COUNT - 1)), $urandom_range(99) < 40);
         end
         drain();
      end

      repeat (20) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // hang guard: resets on every beat taken on either channel
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== keyboard_scancode_translator.f =====
hdl/kst_pkg.sv
hdl/kst_ram.sv
hdl/kst_xlate.sv
hdl/keyboard_scancode_translator.sv
tb/scancode_checker.sv
tb/tb_top.sv
